// File: rtl/core/lfu_pkg.sv
// lfu sorted list engine package: request codes and sequencer states
// no dependencies
`default_nettype none
package lfu_pkg;

  localparam logic [2:0] REQ_ADD         = 3'd0;
  localparam logic [2:0] REQ_REMOVE      = 3'd1;
  localparam logic [2:0] REQ_TOUCH       = 3'd2;
  localparam logic [2:0] REQ_READ_HEAD   = 3'd3;
  localparam logic [2:0] REQ_REMOVE_HEAD = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_ENTRY,
    ST_UNLINK_P,
    ST_UNLINK_N,
    ST_UNLINK_E,
    ST_INS_START,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_INS_POS,
    ST_INS_AFTER,
    ST_INS_E,
    ST_DONE
  } lfu_state_t;

endpackage
`default_nettype wire

// File: rtl/core/lfu_table.sv
// lfu entry table: counts, forward and backward links, listed flags
// uses lfu_pkg only for house style; one read port and one write port per field
`default_nettype none
module lfu_table
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 32,
  localparam int IW = $clog2(ENTRIES),
  localparam int LW = $clog2(ENTRIES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IW-1:0]         rd_addr,
  output logic      [COUNT_BITS-1:0] rd_count,
  output logic      [LW-1:0]         rd_next,
  output logic      [LW-1:0]         rd_prev,
  output logic                       rd_listed,
  input  wire logic                  wr_count_en,
  input  wire logic [IW-1:0]         wr_count_addr,
  input  wire logic [COUNT_BITS-1:0] wr_count,
  input  wire logic                  wr_next_en,
  input  wire logic [IW-1:0]         wr_next_addr,
  input  wire logic [LW-1:0]         wr_next,
  input  wire logic                  wr_prev_en,
  input  wire logic [IW-1:0]         wr_prev_addr,
  input  wire logic [LW-1:0]         wr_prev,
  input  wire logic                  wr_flag_en,
  input  wire logic [IW-1:0]         wr_flag_addr,
  input  wire logic                  wr_flag
);

  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [LW-1:0]         next_mem  [ENTRIES];
  logic [LW-1:0]         prev_mem  [ENTRIES];
  logic [ENTRIES-1:0]    cvalid;
  logic [ENTRIES-1:0]    lvalid;
  logic [ENTRIES-1:0]    listed;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [LW-1:0]         nxt_q;
  logic [LW-1:0]         prv_q;
  logic                  cv_q;
  logic                  lv_q;
  logic                  ls_q;

  // links written together on first use; lvalid covers both
  always_ff @(posedge clk) begin
    if (wr_count_en) count_mem[wr_count_addr] <= wr_count;
    if (wr_next_en) next_mem[wr_next_addr] <= wr_next;
    if (wr_prev_en) prev_mem[wr_prev_addr] <= wr_prev;
    cnt_q <= count_mem[rd_addr];
    nxt_q <= next_mem[rd_addr];
    prv_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
      listed <= '0;
      cv_q   <= 1'b0;
      lv_q   <= 1'b0;
      ls_q   <= 1'b0;
    end else begin
      if (wr_count_en) cvalid[wr_count_addr] <= 1'b1;
      if (wr_flag_en) listed[wr_flag_addr] <= wr_flag;
      cv_q <= cvalid[rd_addr];
      lv_q <= lvalid[rd_addr];
      ls_q <= listed[rd_addr];
    end
  end

  // link valid: both link stores always written in the same insert
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (wr_next_en && wr_prev_en && wr_next_addr == wr_prev_addr) begin
      lvalid[wr_next_addr] <= 1'b1;
    end
  end

  assign rd_count  = cv_q ? cnt_q : '0;
  assign rd_next   = lv_q ? nxt_q : LW'(ENTRIES);
  assign rd_prev   = lv_q ? prv_q : LW'(ENTRIES);
  assign rd_listed = ls_q;

endmodule
`default_nettype wire

// File: rtl/core/lfu_sorted_list_engine.sv
// lfu sorted list engine top level: request sequencer over the entry table
// depends on lfu_pkg and lfu_table
//
// channel   direction  signals
// request   in         req_valid req_ready req_type entry_index use_count
// result    out        res_valid res_ready status list_empty head_entry head_count
//
// the sorted insert walks back from the tail one entry per read and compare
// state pair (walk_rd, walk_cmp) through the single table read port
// reset clears list ends, flags and valid bits directly; no clearing pass
// the result register holds while res_ready is low; no new item until taken
`default_nettype none
module lfu_sorted_list_engine
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [5:0]  entry_index,
  input  wire logic [31:0] use_count,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             status,
  output logic             list_empty,
  output logic [5:0]       head_entry,
  output logic [31:0]      head_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  lfu_state_t state, state_next;

  logic [2:0]            req;
  logic [IW-1:0]         e;
  logic [COUNT_BITS-1:0] cnt;
  logic [LW-1:0]         head_ptr, tail_ptr;
  logic [LW-1:0]         pos, p_l, n_l, after;
  logic [SW-1:0]         steps;
  logic                  do_insert;

  logic [IW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_count;
  logic [LW-1:0]         rd_next, rd_prev;
  logic                  rd_listed;
  logic                  wc_en, wn_en, wp_en, wf_en, wf;
  logic [IW-1:0]         wc_a, wn_a, wp_a, wf_a;
  logic [COUNT_BITS-1:0] wc;
  logic [LW-1:0]         wn, wp;

  logic                  idx_ok;
  logic [63:0]           cnt_in_ext, cnt_wide;

  lfu_table #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_table (
    .clk, .rst,
    .rd_addr, .rd_count, .rd_next, .rd_prev, .rd_listed,
    .wr_count_en(wc_en), .wr_count_addr(wc_a), .wr_count(wc),
    .wr_next_en(wn_en), .wr_next_addr(wn_a), .wr_next(wn),
    .wr_prev_en(wp_en), .wr_prev_addr(wp_a), .wr_prev(wp),
    .wr_flag_en(wf_en), .wr_flag_addr(wf_a), .wr_flag(wf)
  );

  assign idx_ok     = {58'd0, entry_index} < 64'(ENTRIES);
  assign cnt_in_ext = {32'd0, use_count};
  assign cnt_wide   = 64'(CMAX) & cnt_in_ext;
  assign req_ready  = (state == ST_IDLE) && !res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_ready) begin
          priority if (req_type == REQ_READ_HEAD || req_type == REQ_REMOVE_HEAD) begin
            state_next = (head_ptr >= NIL) ? ST_DONE : ST_RD_ENTRY;
          end else if ((req_type == REQ_ADD || req_type == REQ_REMOVE ||
                        req_type == REQ_TOUCH) && idx_ok &&
                       !(req_type == REQ_REMOVE && head_ptr >= NIL)) begin
            state_next = ST_RD_ENTRY;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD_ENTRY: begin
        priority if (req == REQ_ADD) begin
          state_next = rd_listed ? ST_DONE : ST_INS_START;
        end else if (req == REQ_READ_HEAD) begin
          state_next = ST_DONE;
        end else if (rd_listed) begin
          state_next = ST_UNLINK_P;
        end else begin
          state_next = (req == REQ_TOUCH) ? ST_INS_START : ST_DONE;
        end
      end
      ST_UNLINK_P:  state_next = ST_UNLINK_N;
      ST_UNLINK_N:  state_next = ST_UNLINK_E;
      ST_UNLINK_E:  state_next = do_insert ? ST_INS_START : ST_DONE;
      ST_INS_START: state_next = (tail_ptr < NIL) ? ST_WALK_RD : ST_INS_POS;
      ST_WALK_RD:   state_next = ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (rd_count > cnt && {1'b0, steps} < (SW + 1)'(ENTRIES) && rd_prev < NIL) begin
          state_next = ST_WALK_RD;
        end else begin
          state_next = ST_INS_POS;
        end
      end
      ST_INS_POS:   state_next = ST_INS_AFTER;
      ST_INS_AFTER: state_next = ST_INS_E;
      ST_INS_E:     state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // table read address and write strobes
  always_comb begin
    rd_addr = e;
    wc_en = 1'b0; wc_a = e; wc = cnt;
    wn_en = 1'b0; wn_a = e; wn = NIL;
    wp_en = 1'b0; wp_a = e; wp = NIL;
    wf_en = 1'b0; wf_a = e; wf = 1'b0;
    unique case (state)
      ST_IDLE:     rd_addr = (req_type == REQ_READ_HEAD || req_type == REQ_REMOVE_HEAD)
                             ? IW'(head_ptr) : IW'(entry_index);
      ST_UNLINK_P: begin
        wn_en = (p_l < NIL); wn_a = IW'(p_l); wn = n_l;
      end
      ST_UNLINK_N: begin
        wp_en = (n_l < NIL); wp_a = IW'(n_l); wp = p_l;
      end
      ST_UNLINK_E: begin
        wf_en = 1'b1;
      end
      ST_INS_START: begin
        wc_en = 1'b1;
      end
      ST_WALK_RD:  rd_addr = IW'(pos);
      // keeps the insert position's forward link on the read port for ins_pos
      ST_WALK_CMP: rd_addr = IW'(pos);
      ST_INS_POS:  rd_addr = IW'(pos);
      ST_INS_AFTER: begin
        wn_en = (pos < NIL); wn_a = IW'(pos); wn = LW'(e);
        wp_en = (after < NIL); wp_a = IW'(after); wp = LW'(e);
      end
      ST_INS_E: begin
        wn_en = 1'b1; wn = after;
        wp_en = 1'b1; wp = pos;
        wf_en = 1'b1; wf = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_ptr   <= NIL;
      tail_ptr   <= NIL;
      res_valid  <= 1'b0;
      status     <= 1'b0;
      list_empty <= 1'b0;
      head_entry <= '0;
      head_count <= '0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_valid && req_ready) begin
            req        <= req_type;
            e          <= (req_type == REQ_READ_HEAD || req_type == REQ_REMOVE_HEAD)
                          ? IW'(head_ptr) : IW'(entry_index);
            cnt        <= COUNT_BITS'(cnt_wide);
            do_insert  <= (req_type == REQ_TOUCH);
            status     <= 1'b0;
            list_empty <= 1'b0;
            head_entry <= '0;
            head_count <= '0;
            priority if (req_type == REQ_READ_HEAD || req_type == REQ_REMOVE_HEAD) begin
              list_empty <= (head_ptr >= NIL);
            end else if (req_type == REQ_ADD || req_type == REQ_TOUCH) begin
              status <= !idx_ok;
            end else if (req_type == REQ_REMOVE) begin
              status <= !idx_ok || (head_ptr >= NIL);
            end else begin
              status <= 1'b1;
            end
          end
        end
        ST_RD_ENTRY: begin
          p_l <= rd_prev;
          n_l <= rd_next;
          if (req == REQ_ADD && rd_listed) status <= 1'b1;
          if (req == REQ_TOUCH) cnt <= (rd_count < CMAX) ? rd_count + 1'b1 : rd_count;
          if (req == REQ_READ_HEAD || req == REQ_REMOVE_HEAD) begin
            head_entry <= 6'(e);
            head_count <= 32'({32'd0, rd_count});
          end
        end
        ST_UNLINK_P: if (p_l >= NIL) head_ptr <= n_l;
        ST_UNLINK_N: if (n_l >= NIL) tail_ptr <= p_l;
        ST_INS_START: begin
          pos   <= tail_ptr;
          steps <= '0;
        end
        ST_WALK_CMP: begin
          if (rd_count > cnt && {1'b0, steps} < (SW + 1)'(ENTRIES)) begin
            pos   <= rd_prev;
            steps <= steps + 1'b1;
          end
        end
        ST_INS_POS: begin
          if (pos < NIL) begin
            after <= rd_next;
          end else begin
            after    <= head_ptr;
            head_ptr <= LW'(e);
          end
        end
        ST_INS_AFTER: if (after >= NIL) tail_ptr <= LW'(e);
        ST_DONE: res_valid <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
